/* sv/linked_list_engine_unit_assert.svh */
// Assertion macros for the linked list engine.
`ifndef LINKED_LIST_ENGINE_UNIT_ASSERT_SVH
`define LINKED_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define LLE_ASSERT_NOW(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("linked list engine check failed");

// next-cycle implication
`define LLE_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("linked list engine check failed");

`endif

/* sv/lle_pkg.sv */
// Shared types and constants of the linked list engine.
package lle_pkg;

   localparam int DEPTH_DEF       = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int KIND_W   = 3;
   localparam int IO_VAL_W = 32;
   localparam int POS_W    = 6;
   localparam int CNT_W    = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_FRONT  = 3'd0,
      KIND_BACK   = 3'd1,
      KIND_SORTED = 3'd2,
      KIND_SEARCH = 3'd3,
      KIND_REMOVE = 3'd4,
      KIND_POP    = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_NONE  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_ALLOC,
      S_WALK_RD,
      S_WALK_CK,
      S_LINK,
      S_LINK2,
      S_UNLINK,
      S_RELEASE,
      S_POP,
      S_FINISH
   } state_type;

   typedef struct packed {
      status_type           status;
      logic [IO_VAL_W-1:0]  value_out;
      logic [POS_W-1:0]     position;
      logic                 is_empty;
      logic [CNT_W-1:0]     node_count;
   } rsp_type;

endpackage

/* sv/lle_store.sv */
// Node store: value memory and link memory with registered reads.
module lle_store #(
   parameter int DEPTH       = lle_pkg::DEPTH_DEF,
   parameter int VALUE_WIDTH = lle_pkg::VALUE_WIDTH_DEF,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int PTR_W = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic [IDX_W-1:0]              raddr,
   input  logic                          val_we,
   input  logic [IDX_W-1:0]              val_waddr,
   input  logic signed [VALUE_WIDTH-1:0] val_wdata,
   input  logic                          link_we,
   input  logic [IDX_W-1:0]              link_waddr,
   input  logic [PTR_W-1:0]              link_wdata,
   output logic signed [VALUE_WIDTH-1:0] val_rdata,
   output logic [PTR_W-1:0]              link_rdata
);

   logic signed [VALUE_WIDTH-1:0] val_mem [DEPTH];
   logic [PTR_W-1:0]              link_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= val_wdata;
      end
      val_rdata <= val_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rdata <= link_mem[raddr];
   end

endmodule

/* sv/lle_seq.sv */
// Sequencer: list pointers, walk state and the shared compare unit.
module lle_seq #(
   parameter int DEPTH       = lle_pkg::DEPTH_DEF,
   parameter int VALUE_WIDTH = lle_pkg::VALUE_WIDTH_DEF,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int PTR_W = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lle_pkg::KIND_W-1:0]    req_kind,
   input  logic signed [lle_pkg::IO_VAL_W-1:0] req_value,
   input  logic                          slot_free,
   output logic                          fin,
   output lle_pkg::rsp_type              result,
   output logic [IDX_W-1:0]              raddr,
   output logic                          val_we,
   output logic [IDX_W-1:0]              val_waddr,
   output logic signed [VALUE_WIDTH-1:0] val_wdata,
   output logic                          link_we,
   output logic [IDX_W-1:0]              link_waddr,
   output logic [PTR_W-1:0]              link_wdata,
   input  logic signed [VALUE_WIDTH-1:0] val_rdata,
   input  logic [PTR_W-1:0]              link_rdata
);

   localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

   lle_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in, free_ff, free_in;
   logic [PTR_W-1:0] count_ff, count_in, pos_ff, pos_in;
   logic [PTR_W-1:0] prev_ff, prev_in, cur_ff, cur_in, node_ff, node_in;
   lle_pkg::kind_type kind_ff, kind_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in, vout_ff, vout_in;
   lle_pkg::status_type status_ff, status_in;
   logic hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lle_pkg::S_INIT;
         clr_ff   <= '0;
         head_ff  <= NIL;
         tail_ff  <= NIL;
         free_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      prev_ff   <= prev_in;
      cur_ff    <= cur_in;
      node_ff   <= node_in;
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      vout_ff   <= vout_in;
      status_ff <= status_in;
   end

   // shared compare: sorted insert stops at first node not smaller
   assign hit = (kind_ff == lle_pkg::KIND_SORTED) ? !(val_rdata < value_ff)
                                                 : (val_rdata == value_ff);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      free_in   = free_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      node_in   = node_ff;
      kind_in   = kind_ff;
      value_in  = value_ff;
      vout_in   = vout_ff;
      status_in = status_ff;
      req_ready = 1'b0;
      fin       = 1'b0;
      raddr     = cur_ff[IDX_W-1:0];
      val_we    = 1'b0;
      val_waddr = node_ff[IDX_W-1:0];
      val_wdata = value_ff;
      link_we   = 1'b0;
      link_waddr = cur_ff[IDX_W-1:0];
      link_wdata = free_ff;
      unique case (state_ff)
         lle_pkg::S_INIT: begin
            link_we    = 1'b1;
            link_waddr = clr_ff;
            link_wdata = PTR_W'(clr_ff) + PTR_W'(1);
            clr_in     = clr_ff + IDX_W'(1);
            if (clr_ff == LAST) begin
               state_in = lle_pkg::S_IDLE;
            end
         end
         lle_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in   = lle_pkg::kind_type'(req_kind);
               value_in  = VALUE_WIDTH'(req_value);
               pos_in    = '0;
               prev_in   = NIL;
               cur_in    = head_ff;
               status_in = lle_pkg::ST_DONE;
               vout_in   = '0;
               priority case (req_kind)
                  lle_pkg::KIND_FRONT, lle_pkg::KIND_BACK, lle_pkg::KIND_SORTED: begin
                     if (free_ff < NIL) begin
                        node_in  = free_ff;
                        raddr    = free_ff[IDX_W-1:0];
                        state_in = lle_pkg::S_ALLOC;
                     end else begin
                        status_in = lle_pkg::ST_FULL;
                        state_in  = lle_pkg::S_FINISH;
                     end
                  end
                  lle_pkg::KIND_SEARCH, lle_pkg::KIND_REMOVE: begin
                     state_in = lle_pkg::S_WALK_RD;
                  end
                  lle_pkg::KIND_POP: begin
                     if (head_ff < NIL) begin
                        raddr    = head_ff[IDX_W-1:0];
                        state_in = lle_pkg::S_POP;
                     end else begin
                        status_in = lle_pkg::ST_NONE;
                        state_in  = lle_pkg::S_FINISH;
                     end
                  end
                  default: begin
                     status_in = lle_pkg::ST_NONE;
                     state_in  = lle_pkg::S_FINISH;
                  end
               endcase
            end
         end
         lle_pkg::S_ALLOC: begin
            free_in = link_rdata;
            val_we  = 1'b1;
            if (kind_ff == lle_pkg::KIND_BACK) begin
               prev_in  = tail_ff;
               cur_in   = NIL;
               pos_in   = count_ff;
               state_in = lle_pkg::S_LINK;
            end else if (kind_ff == lle_pkg::KIND_SORTED) begin
               state_in = lle_pkg::S_WALK_RD;
            end else begin
               state_in = lle_pkg::S_LINK;
            end
         end
         lle_pkg::S_WALK_RD: begin
            if (cur_ff < NIL) begin
               state_in = lle_pkg::S_WALK_CK;
            end else if (kind_ff == lle_pkg::KIND_SORTED) begin
               state_in = lle_pkg::S_LINK;
            end else begin
               status_in = lle_pkg::ST_NONE;
               pos_in    = '0;
               state_in  = lle_pkg::S_FINISH;
            end
         end
         lle_pkg::S_WALK_CK: begin
            if (!hit) begin
               prev_in  = cur_ff;
               cur_in   = link_rdata;
               pos_in   = pos_ff + PTR_W'(1);
               state_in = lle_pkg::S_WALK_RD;
            end else if (kind_ff == lle_pkg::KIND_SORTED) begin
               state_in = lle_pkg::S_LINK;
            end else if (kind_ff == lle_pkg::KIND_SEARCH) begin
               state_in = lle_pkg::S_FINISH;
            end else begin
               node_in  = link_rdata;
               state_in = lle_pkg::S_UNLINK;
            end
         end
         lle_pkg::S_UNLINK: begin
            if (prev_ff < NIL) begin
               link_we    = 1'b1;
               link_waddr = prev_ff[IDX_W-1:0];
               link_wdata = node_ff;
            end else begin
               head_in = node_ff;
            end
            if (tail_ff == cur_ff) begin
               tail_in = prev_ff;
            end
            state_in = lle_pkg::S_RELEASE;
         end
         lle_pkg::S_RELEASE: begin
            link_we  = 1'b1;
            free_in  = cur_ff;
            count_in = count_ff - PTR_W'(1);
            state_in = lle_pkg::S_FINISH;
         end
         lle_pkg::S_POP: begin
            vout_in = val_rdata;
            head_in = link_rdata;
            if (!(link_rdata < NIL)) begin
               tail_in = NIL;
            end
            link_we  = 1'b1;
            free_in  = cur_ff;
            count_in = count_ff - PTR_W'(1);
            state_in = lle_pkg::S_FINISH;
         end
         lle_pkg::S_LINK: begin
            link_we    = 1'b1;
            link_waddr = node_ff[IDX_W-1:0];
            link_wdata = cur_ff;
            if (!(cur_ff < NIL)) begin
               tail_in = node_ff;
            end
            count_in = count_ff + PTR_W'(1);
            if (prev_ff < NIL) begin
               state_in = lle_pkg::S_LINK2;
            end else begin
               head_in  = node_ff;
               state_in = lle_pkg::S_FINISH;
            end
         end
         lle_pkg::S_LINK2: begin
            link_we    = 1'b1;
            link_waddr = prev_ff[IDX_W-1:0];
            link_wdata = node_ff;
            state_in   = lle_pkg::S_FINISH;
         end
         lle_pkg::S_FINISH: begin
            fin = 1'b1;
            if (slot_free) begin
               state_in = lle_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lle_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      result.status     = status_ff;
      result.value_out  = lle_pkg::IO_VAL_W'(vout_ff);
      result.position   = lle_pkg::POS_W'(pos_ff);
      result.is_empty   = !(head_ff < NIL);
      result.node_count = lle_pkg::CNT_W'(count_ff);
   end

endmodule

/* sv/linked_list_engine_unit.sv */
// Top level of the linked list engine: sequencer, node store, response register.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    req_kind, req_value
//   rsp_     out        rsp_valid/rsp_ready    status, value_out, position, is_empty, node_count
//
// After reset a clearing pass over all DEPTH entries chains the link memory; no request is taken then.
// Front insert runs ALLOC and LINK; back insert adds LINK2 with a non-empty list; pop runs POP;
// search, remove and sorted insert walk the list with one memory read per node visited.
// One request at a time; a finished response waits in its register while the next is taken.
module linked_list_engine_unit #(
   parameter int DEPTH       = lle_pkg::DEPTH_DEF,
   parameter int VALUE_WIDTH = lle_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lle_pkg::KIND_W-1:0]           req_kind,
   input  logic signed [lle_pkg::IO_VAL_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic signed [lle_pkg::IO_VAL_W-1:0]  rsp_value_out,
   output logic [lle_pkg::POS_W-1:0]            rsp_position,
   output logic                                 rsp_is_empty,
   output logic [lle_pkg::CNT_W-1:0]            rsp_node_count
);

   `include "linked_list_engine_unit_assert.svh"

   localparam int IDX_W = $clog2(DEPTH);
   localparam int PTR_W = $clog2(DEPTH + 1);

   logic [IDX_W-1:0]              raddr, val_waddr, link_waddr;
   logic                          val_we, link_we, fin, slot_free;
   logic signed [VALUE_WIDTH-1:0] val_wdata, val_rdata;
   logic [PTR_W-1:0]              link_wdata, link_rdata;
   lle_pkg::rsp_type              result, rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   lle_seq #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_seq (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_value(req_value),
      .slot_free(slot_free), .fin(fin), .result(result),
      .raddr(raddr),
      .val_we(val_we), .val_waddr(val_waddr), .val_wdata(val_wdata),
      .link_we(link_we), .link_waddr(link_waddr), .link_wdata(link_wdata),
      .val_rdata(val_rdata), .link_rdata(link_rdata)
   );

   lle_store #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_store (
      .clock(clock), .raddr(raddr),
      .val_we(val_we), .val_waddr(val_waddr), .val_wdata(val_wdata),
      .link_we(link_we), .link_waddr(link_waddr), .link_wdata(link_wdata),
      .val_rdata(val_rdata), .link_rdata(link_rdata)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fin && slot_free) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_value_out  = rsp_ff.value_out;
   assign rsp_position   = rsp_ff.position;
   assign rsp_is_empty   = rsp_ff.is_empty;
   assign rsp_node_count = rsp_ff.node_count;

   `LLE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `LLE_ASSERT_NOW(a_empty_count, clock, reset, rsp_valid, rsp_is_empty == (rsp_node_count == '0))
   `LLE_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, rsp_node_count <= lle_pkg::CNT_W'(DEPTH))
   `LLE_ASSERT_NOW(a_full_is_insert, clock, reset, fin && result.status == lle_pkg::ST_FULL, result.node_count == lle_pkg::CNT_W'(DEPTH))

endmodule
